// ===== hw/rtl/nearest_palette_color_defines.svh =====
// Assertion macros for the nearest palette color block.
`ifndef NEAREST_PALETTE_COLOR_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define NPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that one condition implies another in the next cycle.
`define NPC_ASSERT_NEXT(label, cond, conseq, msg) \
  `NPC_ASSERT(label, (cond) |=> (conseq), msg)

`endif

// ===== hw/rtl/npc_pkg.sv =====
`timescale 1ns / 1ps
package npc_pkg;

  localparam int IndexReach = 64;
  localparam int ResetColors = 56;
  localparam logic [6:0] ResetCount = 7'd56;
  localparam logic OpClassify = 1'b0;
  localparam logic OpWrite = 1'b1;

  typedef struct packed {
    logic wr_en;
    logic pix_load;
    logic rd_en;
    logic first;
    logic last;
  } cmd_t;

  function automatic logic [23:0] reset_color(input logic [7:0] idx);
    logic [23:0] c;
    case (idx)
      8'd0: c = 24'hff0000;
      8'd1: c = 24'h00ff00;
      8'd2: c = 24'h0000ff;
      8'd3: c = 24'hffc0cb;
      8'd4: c = 24'hdc143c;
      8'd5: c = 24'hff1493;
      8'd6: c = 24'hda70d6;
      8'd7: c = 24'hee82ee;
      8'd8: c = 24'hff00ff;
      8'd9: c = 24'h800080;
      8'd10: c = 24'h9400d3;
      8'd11: c = 24'h9932cc;
      8'd12: c = 24'h4b0082;
      8'd13: c = 24'h6a5acd;
      8'd14: c = 24'h483d8b;
      8'd15: c = 24'he6e6fa;
      8'd16: c = 24'h191970;
      8'd17: c = 24'h00008b;
      8'd18: c = 24'h4169e1;
      8'd19: c = 24'h6495ed;
      8'd20: c = 24'hb0c4de;
      8'd21: c = 24'h708090;
      8'd22: c = 24'h4682b4;
      8'd23: c = 24'h87ceeb;
      8'd24: c = 24'h00bfff;
      8'd25: c = 24'h5f9ea0;
      8'd26: c = 24'hf0ffff;
      8'd27: c = 24'h00ffff;
      8'd28: c = 24'h2f4f4f;
      8'd29: c = 24'h008b8b;
      8'd30: c = 24'h40e0d0;
      8'd31: c = 24'h7fffaa;
      8'd32: c = 24'h3cb371;
      8'd33: c = 24'h90ee90;
      8'd34: c = 24'h006400;
      8'd35: c = 24'hadff2f;
      8'd36: c = 24'hf5f5dc;
      8'd37: c = 24'hffff00;
      8'd38: c = 24'h808000;
      8'd39: c = 24'hf0e68c;
      8'd40: c = 24'hffd700;
      8'd41: c = 24'hf5deb3;
      8'd42: c = 24'hffa500;
      8'd43: c = 24'hffdab9;
      8'd44: c = 24'hf4a460;
      8'd45: c = 24'hd2691e;
      8'd46: c = 24'hff7f50;
      8'd47: c = 24'hff4500;
      8'd48: c = 24'hff6347;
      8'd49: c = 24'hf08080;
      8'd50: c = 24'ha52a2a;
      8'd51: c = 24'h800000;
      8'd52: c = 24'hffffff;
      8'd53: c = 24'h808080;
      8'd54: c = 24'ha9a9a9;
      8'd55: c = 24'h000000;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/npc_ctrl.sv =====
`timescale 1ns / 1ps
module npc_ctrl #(
  parameter int PALETTE_DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             operation_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [6:0]                       cfg_data_i,
  input  logic                             scan_done_i,
  output npc_pkg::cmd_t                    cmd_o,
  output logic [$clog2(PALETTE_DEPTH)-1:0] addr_o
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int MaxN = (PALETTE_DEPTH < npc_pkg::IndexReach) ? PALETTE_DEPTH
                                                               : npc_pkg::IndexReach;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [6:0]    entries_q;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] last_q, last_d;
  logic [6:0]    n_eff;
  logic [6:0]    last_full;
  logic [31:0]   last_ext;
  logic          accept;
  logic          at_last;

  assign busy        = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign at_last     = (cnt_q == last_q);
  assign addr_o      = cnt_q;

  always_comb begin
    if (entries_q == 7'd0) begin
      n_eff = 7'd1;
    end else if (entries_q > 7'(MaxN)) begin
      n_eff = 7'(MaxN);
    end else begin
      n_eff = entries_q;
    end
    last_full = n_eff - 7'd1;
    last_ext  = 32'(last_full);
  end

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    last_d         = last_q;
    cmd_o          = '0;
    cmd_o.first    = (cnt_q == '0);
    cmd_o.last     = at_last;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (operation_i == npc_pkg::OpWrite) begin
            cmd_o.wr_en = 1'b1;
          end else begin
            cmd_o.pix_load = 1'b1;
            cnt_d          = '0;
            last_d         = last_ext[AW-1:0];
            state_d        = StScan;
          end
        end
      end
      StScan: begin
        cmd_o.rd_en = 1'b1;
        if (at_last) begin
          state_d = StDrain;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StDrain: begin
        if (scan_done_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      last_q    <= '0;
      entries_q <= npc_pkg::ResetCount;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      if (cfg_valid_i && cfg_ready_o) begin
        entries_q <= cfg_data_i;
      end
    end
  end

endmodule

// ===== hw/rtl/npc_datapath.sv =====
`timescale 1ns / 1ps
module npc_datapath #(
  parameter int PALETTE_DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  npc_pkg::cmd_t                    cmd_i,
  input  logic [$clog2(PALETTE_DEPTH)-1:0] addr_i,
  input  logic [15:0]                      pixel_rgb565_i,
  input  logic [5:0]                       entry_index_i,
  input  logic [23:0]                      entry_rgb888_i,
  output logic                             scan_done_o,
  output logic                             result_valid_o,
  output logic [5:0]                       color_index_o,
  output logic [17:0]                      color_distance_o
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [23:0]              mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] written_q;

  logic [7:0]    r_q, g_q, b_q;
  logic [23:0]   rdata_q;
  logic          rwritten_q;
  logic          s1_valid_q, s1_first_q, s1_last_q;
  logic [AW-1:0] s1_idx_q;
  logic [15:0]   sq_r_q, sq_g_q, sq_b_q;
  logic          s2_valid_q, s2_first_q, s2_last_q;
  logic [AW-1:0] s2_idx_q;
  logic [17:0]   best_dist_q;
  logic [AW-1:0] best_idx_q;
  logic          result_valid_q;
  logic [5:0]    color_index_q;
  logic [17:0]   color_distance_q;

  logic [31:0]   widx_ext;
  logic [AW-1:0] waddr;
  logic          wr_hit;
  logic [23:0]   color;
  logic [7:0]    dr, dg, db;
  logic [17:0]   sum;
  logic          take;
  logic [AW-1:0] new_idx;
  logic [17:0]   new_dist;
  logic [31:0]   out_idx_ext;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  assign widx_ext = 32'(entry_index_i);
  assign waddr    = widx_ext[AW-1:0];
  assign wr_hit   = cmd_i.wr_en && (widx_ext < 32'(PALETTE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      mem[waddr] <= entry_rgb888_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (wr_hit) begin
      written_q[waddr] <= 1'b1;
    end
  end

  always_comb begin
    color = rwritten_q ? rdata_q : npc_pkg::reset_color(8'(s1_idx_q));
    dr    = abs_diff(r_q, color[23:16]);
    dg    = abs_diff(g_q, color[15:8]);
    db    = abs_diff(b_q, color[7:0]);
  end

  always_comb begin
    sum      = 18'(sq_r_q) + 18'(sq_g_q) + 18'(sq_b_q);
    take     = s2_first_q || (sum < best_dist_q);
    new_idx  = take ? s2_idx_q : best_idx_q;
    new_dist = take ? sum : best_dist_q;
    out_idx_ext = 32'(new_idx);
  end

  assign scan_done_o = s2_valid_q && s2_last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_load) begin
      r_q <= {pixel_rgb565_i[15:11], 3'b000};
      g_q <= {pixel_rgb565_i[10:5], 2'b00};
      b_q <= {pixel_rgb565_i[4:0], 3'b000};
    end
    rwritten_q <= written_q[addr_i];
    s1_first_q <= cmd_i.first;
    s1_last_q  <= cmd_i.last;
    s1_idx_q   <= addr_i;
    sq_r_q     <= 16'(dr * dr);
    sq_g_q     <= 16'(dg * dg);
    sq_b_q     <= 16'(db * db);
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_idx_q   <= s1_idx_q;
    if (s2_valid_q) begin
      best_dist_q <= new_dist;
      best_idx_q  <= new_idx;
    end
    if (scan_done_o) begin
      color_index_q    <= out_idx_ext[5:0];
      color_distance_q <= new_dist;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q     <= 1'b0;
      s2_valid_q     <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      s1_valid_q     <= cmd_i.rd_en;
      s2_valid_q     <= s1_valid_q;
      result_valid_q <= scan_done_o;
    end
  end

  assign result_valid_o   = result_valid_q;
  assign color_index_o    = color_index_q;
  assign color_distance_o = color_distance_q;

endmodule

// ===== hw/rtl/nearest_palette_color.sv =====
// Nearest palette color search, one palette entry compared per cycle.
// Classify: the n entries searched pass the read and squared-difference registers
// and the compare; busy stays high until the strobe, so pixels do not overlap.
// Palette write: done at the accepting edge, no result, next item the next cycle.
// Reset clears the written flags, so the palette reads back the built-in colors.
// The receiver cannot stall: result_valid_o is high for exactly one cycle per result.
`timescale 1ns / 1ps
module nearest_palette_color #(
  parameter int PALETTE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        operation_i,
  input  logic [15:0] pixel_rgb565_i,
  input  logic [5:0]  entry_index_i,
  input  logic [23:0] entry_rgb888_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,
  output logic        result_valid_o,
  output logic [5:0]  color_index_o,
  output logic [17:0] color_distance_o
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  npc_pkg::cmd_t cmd;
  logic [AW-1:0] addr;
  logic          scan_done;

  npc_ctrl #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .operation_i (operation_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .scan_done_i (scan_done),
    .cmd_o       (cmd),
    .addr_o      (addr)
  );

  npc_datapath #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .addr_i           (addr),
    .pixel_rgb565_i   (pixel_rgb565_i),
    .entry_index_i    (entry_index_i),
    .entry_rgb888_i   (entry_rgb888_i),
    .scan_done_o      (scan_done),
    .result_valid_o   (result_valid_o),
    .color_index_o    (color_index_o),
    .color_distance_o (color_distance_o)
  );

endmodule

// ===== hw/rtl/npc_checker.sv =====
`timescale 1ns / 1ps
`include "nearest_palette_color_defines.svh"
module npc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        operation_i,
  input logic        result_valid_o,
  input logic [17:0] color_distance_o
);

  `NPC_ASSERT_NEXT(a_classify_busy, start && !busy && (operation_i == npc_pkg::OpClassify), busy, "classify beat did not raise busy")
  `NPC_ASSERT_NEXT(a_accept_no_result, start && !busy, !result_valid_o, "result right after an accepted beat")
  `NPC_ASSERT(a_fall_gives_result, $fell(busy) |-> result_valid_o, "busy dropped without a result")
  `NPC_ASSERT(a_dist_bound, result_valid_o |-> (color_distance_o <= 18'd195075), "distance out of range")

endmodule

bind nearest_palette_color npc_checker u_npc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .operation_i      (operation_i),
  .result_valid_o   (result_valid_o),
  .color_distance_o (color_distance_o)
);
